// ===== design/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Sizes, request and status codes, and the command bundle for the cell row.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK       = 3'd4,
    OP_LIST       = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_REAR,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         count;
    logic signed [WORD_W-1:0] word;
  } cell_cmd_t;

endpackage

// ===== design/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell: one storage slot of the deque row
// Holds one word; loads from a neighbor, the pushed word or the head word.
// ----------------------------------------------------------------------------
module deq_cell (
  input  logic                                 clk,
  input  deq_pkg::cell_cmd_t                   cmd,
  input  logic [deq_pkg::IDX_W-1:0]            pos,
  input  logic signed [deq_pkg::WORD_W-1:0]    left_in,
  input  logic signed [deq_pkg::WORD_W-1:0]    right_in,
  input  logic signed [deq_pkg::WORD_W-1:0]    head_in,
  output logic signed [deq_pkg::WORD_W-1:0]    word
);

  logic signed [deq_pkg::WORD_W-1:0] word_next;
  logic [deq_pkg::CNT_W-1:0]         pos_ext;
  logic [deq_pkg::CNT_W-1:0]         pos_plus1;

  assign pos_ext   = deq_pkg::CNT_W'(pos);
  assign pos_plus1 = pos_ext + deq_pkg::CNT_W'(1);

  always_comb begin
    word_next = word;
    case (cmd.op)
      deq_pkg::CELL_PUSH_FRONT: word_next = left_in;
      deq_pkg::CELL_PUSH_REAR: begin
        if (pos_ext == cmd.count) word_next = cmd.word;
      end
      deq_pkg::CELL_POP_FRONT: word_next = right_in;
      deq_pkg::CELL_ROTATE: begin
        // advance toward the front; the tail slot takes the old head
        if (pos_plus1 == cmd.count) word_next = head_in;
        else if (pos_plus1 < cmd.count) word_next = right_in;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== design/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_unit: deque of signed words in a row of shifting cells
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low: operation
// selects push front, push rear, pop front, pop rear, peek or list, and value
// is the word to push. Results come out on status, data and last for exactly
// one cycle, marked by done; the receiver cannot stall them.
// The words sit in order in a row of DEPTH cells, front in cell 0. Push front
// and pop front shift the whole row by one cell; push rear loads the cell at
// the current count; pop rear only lowers the count.
// Push, pop and peek give their single result one cycle after acceptance and
// keep busy low, so one such request may be taken every cycle.
// List raises busy and rotates the occupied cells once per cycle, emitting
// the front cell each time: a list of N words gives N results, one per
// cycle with no gap, the first registered once the list state has begun,
// last marking the final one; busy drops in the cycle of the last result.
// An empty list gives one empty result like a push, pop or peek request.
// Unknown request codes give one ok result and change nothing.
// Reset empties the deque and returns to idle; cell contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        operation,
  input  logic signed [deq_pkg::WORD_W-1:0] value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [deq_pkg::WORD_W-1:0] data,
  output logic                              last
);

  deq_pkg::state_t                    state, state_next;
  logic [deq_pkg::CNT_W-1:0]          count, count_next;
  logic [deq_pkg::IDX_W-1:0]          list_idx, list_idx_next;
  logic                               done_next;
  logic [1:0]                         status_next;
  logic signed [deq_pkg::WORD_W-1:0]  data_next;
  logic                               last_next;
  logic                               accept;
  logic                               list_end;
  deq_pkg::cell_cmd_t                 cmd;
  logic signed [deq_pkg::WORD_W-1:0]  cells [deq_pkg::DEPTH];

  assign busy     = (state == deq_pkg::ST_LIST);
  assign accept   = start && !busy;
  assign list_end = ((deq_pkg::CNT_W'(list_idx) + deq_pkg::CNT_W'(1)) == count);

  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    logic signed [deq_pkg::WORD_W-1:0] left_w;
    logic signed [deq_pkg::WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = value;
    end else begin : g_mid_l
      assign left_w = cells[i-1];
    end
    if (i == deq_pkg::DEPTH - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cells[i+1];
    end
    deq_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (deq_pkg::IDX_W'(i)),
      .left_in  (left_w),
      .right_in (right_w),
      .head_in  (cells[0]),
      .word     (cells[i])
    );
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    list_idx_next = list_idx;
    done_next     = 1'b0;
    status_next   = deq_pkg::STATUS_OK;
    data_next     = '0;
    last_next     = 1'b1;
    cmd.op        = deq_pkg::CELL_HOLD;
    cmd.count     = count;
    cmd.word      = value;

    if (state == deq_pkg::ST_LIST) begin
      cmd.op    = deq_pkg::CELL_ROTATE;
      done_next = 1'b1;
      data_next = cells[0];
      last_next = list_end;
      if (list_end) begin
        state_next    = deq_pkg::ST_IDLE;
        list_idx_next = '0;
      end else begin
        list_idx_next = list_idx + deq_pkg::IDX_W'(1);
      end
    end else if (accept) begin
      done_next = 1'b1;
      case (deq_pkg::op_t'(operation))
        deq_pkg::OP_PUSH_FRONT,
        deq_pkg::OP_PUSH_REAR: begin
          if (count == deq_pkg::CNT_W'(deq_pkg::DEPTH)) begin
            status_next = deq_pkg::STATUS_FULL;
          end else begin
            cmd.op = (deq_pkg::op_t'(operation) == deq_pkg::OP_PUSH_FRONT) ?
                     deq_pkg::CELL_PUSH_FRONT : deq_pkg::CELL_PUSH_REAR;
            count_next = count + deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_FRONT,
        deq_pkg::OP_POP_REAR: begin
          if (count == '0) begin
            status_next = deq_pkg::STATUS_EMPTY;
          end else begin
            if (deq_pkg::op_t'(operation) == deq_pkg::OP_POP_FRONT)
              cmd.op = deq_pkg::CELL_POP_FRONT;
            count_next = count - deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::OP_PEEK: begin
          if (count == '0) status_next = deq_pkg::STATUS_EMPTY;
          else data_next = cells[0];
        end
        deq_pkg::OP_LIST: begin
          if (count == '0) begin
            status_next = deq_pkg::STATUS_EMPTY;
          end else begin
            // hold the result until the row starts rotating
            done_next     = 1'b0;
            state_next    = deq_pkg::ST_LIST;
            list_idx_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= deq_pkg::ST_IDLE;
      count    <= '0;
      list_idx <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      list_idx <= list_idx_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
    data   <= data_next;
    last   <= last_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("occupancy above deque depth");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && count == deq_pkg::CNT_W'(deq_pkg::DEPTH) &&
     (operation == deq_pkg::OP_PUSH_FRONT || operation == deq_pkg::OP_PUSH_REAR))
    |=> (done && status == deq_pkg::STATUS_FULL && $stable(count)))
    else $error("push on full deque not dropped");

  a_list_emits: assert property (@(posedge clk) disable iff (rst)
    (state == deq_pkg::ST_LIST) |=> done)
    else $error("list cycle without a result");

  a_list_idx: assert property (@(posedge clk) disable iff (rst)
    (state == deq_pkg::ST_LIST) |-> (deq_pkg::CNT_W'(list_idx) < count && $stable(count)))
    else $error("list index past occupancy");

endmodule
